FILE: src/wkclk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wkclk_pkg
// Shared types and constants of the weekday clock with sleep and wake alarms.
// ----------------------------------------------------------------------------
package wkclk_pkg;

  localparam int unsigned SEC_W  = 6;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned WDAY_W = 3;
  localparam int unsigned ELAPSED_W = 15;
  localparam int unsigned SUBSEC_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);
  localparam logic [WDAY_W-1:0] WDAY_LAST = WDAY_W'(7);
  localparam logic [WDAY_W-1:0] WDAY_MON  = WDAY_W'(1);

  // Register index bit 2 selects the alarm, bits 1:0 the field.
  localparam logic CFG_BANK_SLEEP = 1'b0;
  localparam logic CFG_BANK_WAKE  = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_ARM_SLEEP = 2'd1,
    OP_ARM_WAKE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    FLD_SECOND  = 2'd0,
    FLD_MINUTE  = 2'd1,
    FLD_HOUR    = 2'd2,
    FLD_WEEKDAY = 2'd3
  } field_t;

  typedef struct packed {
    logic [SEC_W-1:0]  second;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [WDAY_W-1:0] weekday;
  } clk_time_t;

  typedef struct packed {
    logic fired;
    logic armed;
  } alarm_stat_t;

endpackage

`default_nettype wire

FILE: src/wkclk_time.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wkclk_time
// Subsecond accumulator and second/minute/hour/weekday cascade.
// ----------------------------------------------------------------------------
module wkclk_time #(
  parameter int unsigned COUNTS_PER_SECOND = 20000
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             tick,
  input  wire logic [wkclk_pkg::ELAPSED_W-1:0]  elapsed,
  output wkclk_pkg::clk_time_t                  time_nxt,
  output logic                                  adv
);
  import wkclk_pkg::*;

  localparam logic [SUBSEC_W-1:0] PERIOD = SUBSEC_W'(COUNTS_PER_SECOND);

  logic [SUBSEC_W-1:0] subsec_r;
  logic [SUBSEC_W-1:0] subsec_nxt;
  logic [SUBSEC_W:0]   sum;
  logic [SUBSEC_W-1:0] sat;
  clk_time_t           time_r;
  clk_time_t           cascade;

  always_comb begin
    sum = {1'b0, subsec_r} + {{(SUBSEC_W + 1 - ELAPSED_W){1'b0}}, elapsed};
    sat = sum[SUBSEC_W] ? {SUBSEC_W{1'b1}} : sum[SUBSEC_W-1:0];
    adv = tick && (sat >= PERIOD);
    subsec_nxt = subsec_r;
    if (tick) begin
      subsec_nxt = adv ? (sat - PERIOD) : sat;
    end
  end

  always_comb begin
    cascade = time_r;
    if (time_r.second == SEC_LAST) begin
      cascade.second = '0;
      if (time_r.minute == MIN_LAST) begin
        cascade.minute = '0;
        if (time_r.hour == HOUR_LAST) begin
          cascade.hour = '0;
          cascade.weekday = (time_r.weekday == WDAY_LAST) ? WDAY_MON
                                                          : time_r.weekday + 1'b1;
        end else begin
          cascade.hour = time_r.hour + 1'b1;
        end
      end else begin
        cascade.minute = time_r.minute + 1'b1;
      end
    end else begin
      cascade.second = time_r.second + 1'b1;
    end
    time_nxt = adv ? cascade : time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subsec_r <= '0;
      time_r   <= '0;
    end else begin
      subsec_r <= subsec_nxt;
      time_r   <= time_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/wkclk_alarm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wkclk_alarm
// One-shot alarm: setting registers, arm flag and pending check per second.
// ----------------------------------------------------------------------------
module wkclk_alarm (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire logic                              arm,
  input  wire logic                              adv,
  input  wire wkclk_pkg::clk_time_t              now,
  input  wire logic                              cfg_we,
  input  wire wkclk_pkg::field_t                 cfg_field,
  input  wire logic [wkclk_pkg::CFG_DATA_W-1:0]  cfg_data,
  output wkclk_pkg::alarm_stat_t                 stat
);
  import wkclk_pkg::*;

  clk_time_t set_r;
  logic      armed_r;
  logic      armed_nxt;
  logic      due_r;
  logic      due_nxt;
  logic      armed_in;
  logic      due_in;
  logic      match;

  always_comb begin
    armed_in  = armed_r || arm;
    due_in    = due_r || adv;
    match     = (now == set_r);
    armed_nxt = armed_in;
    due_nxt   = due_in;
    stat.fired = 1'b0;
    if (armed_in && due_in) begin
      due_nxt = 1'b0;
      if (match) begin
        armed_nxt  = 1'b0;
        stat.fired = 1'b1;
      end
    end
    stat.armed = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      due_r   <= 1'b0;
    end else if (step) begin
      armed_r <= armed_nxt;
      due_r   <= due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r <= '0;
    end else if (cfg_we) begin
      case (cfg_field)
        FLD_SECOND:  set_r.second  <= cfg_data[SEC_W-1:0];
        FLD_MINUTE:  set_r.minute  <= cfg_data[MIN_W-1:0];
        FLD_HOUR:    set_r.hour    <= cfg_data[HOUR_W-1:0];
        FLD_WEEKDAY: set_r.weekday <= cfg_data[WDAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/weekday_clock_with_alarms_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weekday_clock_with_alarms_unit
// Weekday clock fed by subsecond ticks, with one-shot sleep and wake alarms.
// ----------------------------------------------------------------------------
// Result path: input register, then one pass through clock and alarm logic
//   into the result register.
// Throughput: one transaction per cycle; while a result waits, the input
//   register takes one more transaction, then the input stalls.
// Reset (rst_n low, synchronous): time, accumulator, alarm flags and alarm
//   settings clear to zero; no result is pending.
module weekday_clock_with_alarms_unit #(
  parameter int unsigned COUNTS_PER_SECOND = 20000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_operation,
  input  wire logic [wkclk_pkg::ELAPSED_W-1:0]   in_elapsed_counts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [wkclk_pkg::SEC_W-1:0]            out_now_second,
  output logic [wkclk_pkg::MIN_W-1:0]            out_now_minute,
  output logic [wkclk_pkg::HOUR_W-1:0]           out_now_hour,
  output logic [wkclk_pkg::WDAY_W-1:0]           out_now_weekday,
  output logic                                   out_sleep_fired,
  output logic                                   out_wake_fired,
  output logic                                   out_sleep_is_armed,
  output logic                                   out_wake_is_armed,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wkclk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [wkclk_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wkclk_pkg::*;

  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  logic [ELAPSED_W-1:0] s1_elapsed_r;
  logic                 s1_fire;
  logic                 out_valid_r;
  logic                 tick;
  logic                 arm_sleep;
  logic                 arm_wake;
  logic                 adv;
  clk_time_t            time_nxt;
  clk_time_t            now_r;
  alarm_stat_t          sleep_stat;
  alarm_stat_t          wake_stat;
  alarm_stat_t          sleep_r;
  alarm_stat_t          wake_r;
  logic                 cfg_we;
  field_t               cfg_field;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_field = field_t'(cfg_index[1:0]);

  always_comb begin
    tick      = 1'b0;
    arm_sleep = 1'b0;
    arm_wake  = 1'b0;
    case (op_t'(s1_op_r))
      OP_TICK:      tick      = s1_fire;
      OP_ARM_SLEEP: arm_sleep = s1_fire;
      OP_ARM_WAKE:  arm_wake  = s1_fire;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r      <= in_operation;
      s1_elapsed_r <= in_elapsed_counts;
    end
    if (s1_fire) begin
      now_r   <= time_nxt;
      sleep_r <= sleep_stat;
      wake_r  <= wake_stat;
    end
  end

  wkclk_time #(
    .COUNTS_PER_SECOND(COUNTS_PER_SECOND)
  ) u_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .elapsed  (s1_elapsed_r),
    .time_nxt (time_nxt),
    .adv      (adv)
  );

  wkclk_alarm u_sleep (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .arm       (arm_sleep),
    .adv       (adv),
    .now       (time_nxt),
    .cfg_we    (cfg_we && (cfg_index[2] == CFG_BANK_SLEEP)),
    .cfg_field (cfg_field),
    .cfg_data  (cfg_data),
    .stat      (sleep_stat)
  );

  wkclk_alarm u_wake (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .arm       (arm_wake),
    .adv       (adv),
    .now       (time_nxt),
    .cfg_we    (cfg_we && (cfg_index[2] == CFG_BANK_WAKE)),
    .cfg_field (cfg_field),
    .cfg_data  (cfg_data),
    .stat      (wake_stat)
  );

  assign out_valid          = out_valid_r;
  assign out_now_second     = now_r.second;
  assign out_now_minute     = now_r.minute;
  assign out_now_hour       = now_r.hour;
  assign out_now_weekday    = now_r.weekday;
  assign out_sleep_fired    = sleep_r.fired;
  assign out_wake_fired     = wake_r.fired;
  assign out_sleep_is_armed = sleep_r.armed;
  assign out_wake_is_armed  = wake_r.armed;

endmodule

`default_nettype wire

FILE: src/wkclk_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wkclk_checker
// Port-level checks of the weekday clock, bound to the top level.
// ----------------------------------------------------------------------------
module wkclk_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_now_second,
  input wire logic [5:0] out_now_minute,
  input wire logic [4:0] out_now_hour,
  input wire logic [2:0] out_now_weekday,
  input wire logic       out_sleep_fired,
  input wire logic       out_wake_fired,
  input wire logic       out_sleep_is_armed,
  input wire logic       out_wake_is_armed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_now_second) &&
      $stable(out_now_minute) && $stable(out_now_hour) && $stable(out_now_weekday))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sleep_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sleep_fired |-> !out_sleep_is_armed)
    else $error("sleep alarm fired but stays armed");

  a_wake_disarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_fired |-> !out_wake_is_armed)
    else $error("wake alarm fired but stays armed");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_now_second < 6'd60) && (out_now_minute < 6'd60) &&
      (out_now_hour < 5'd24))
    else $error("time field out of range");

endmodule

bind weekday_clock_with_alarms_unit wkclk_checker u_wkclk_checker (.*);

`default_nettype wire

FILE: sim/weekday_clock_with_alarms_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weekday_clock_with_alarms_unit_tb
// Self-checking bench for the weekday clock with sleep and wake alarms. Tick,
// arm and unused transactions go in under random stalls on both channels.
// Every result is compared field by field against an in-bench clock and
// alarm model, which also tracks the alarm registers written through the
// config port. Directed tests cover accumulator saturation, alarms firing on
// ticks and on arm transactions, settings that can never match, and output
// back-pressure. Random rounds aim most alarms up to 40 seconds ahead.
// A final stall-free run ticks one second per transaction past both alarms.
// ----------------------------------------------------------------------------
module weekday_clock_with_alarms_unit_tb;
  import wkclk_pkg::*;

  localparam int unsigned CLK_PERIOD        = 12;
  localparam int unsigned COUNTS_PER_SECOND = 20000;
  localparam int unsigned DRAIN_CYCLES      = 4;
  localparam int unsigned SETTLE_CYCLES     = 20;
  localparam longint      TIMEOUT_CYCLES    = 4_000_000;
  localparam logic [1:0]  OP_UNUSED         = 2'd3;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    clk_time_t   now;
    alarm_stat_t sleep_stat;
    alarm_stat_t wake_stat;
  } clock_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_TICK;
  logic [ELAPSED_W-1:0] in_elapsed_counts = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SEC_W-1:0] out_now_second;
  logic [MIN_W-1:0] out_now_minute;
  logic [HOUR_W-1:0] out_now_hour;
  logic [WDAY_W-1:0] out_now_weekday;
  logic out_sleep_fired;
  logic out_wake_fired;
  logic out_sleep_is_armed;
  logic out_wake_is_armed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model state
  clk_time_t clock_now = '0;
  logic [SUBSEC_W-1:0] subsec_acc = '0;
  logic sleep_armed = 1'b0;
  logic wake_armed = 1'b0;
  logic sleep_due = 1'b0;
  logic wake_due = 1'b0;
  clk_time_t sleep_alarm_at = '0;
  clk_time_t wake_alarm_at = '0;

  clock_report_t pending_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned hold_off_cycles = 0;
  bit idling_on = 1'b0;

  weekday_clock_with_alarms_unit #(
    .COUNTS_PER_SECOND(COUNTS_PER_SECOND)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_elapsed_counts(in_elapsed_counts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_now_second(out_now_second),
    .out_now_minute(out_now_minute),
    .out_now_hour(out_now_hour),
    .out_now_weekday(out_now_weekday),
    .out_sleep_fired(out_sleep_fired),
    .out_wake_fired(out_wake_fired),
    .out_sleep_is_armed(out_sleep_is_armed),
    .out_wake_is_armed(out_wake_is_armed),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic clk_time_t next_second(clk_time_t t);
    clk_time_t r;
    r = t;
    if (r.second < SEC_LAST) begin
      r.second = r.second + 1'b1;
    end else begin
      r.second = '0;
      if (r.minute < MIN_LAST) begin
        r.minute = r.minute + 1'b1;
      end else begin
        r.minute = '0;
        if (r.hour < HOUR_LAST) begin
          r.hour = r.hour + 1'b1;
        end else begin
          r.hour = '0;
          r.weekday = (r.weekday == WDAY_LAST) ? WDAY_MON : r.weekday + 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic clk_time_t later_by(clk_time_t t, int unsigned secs);
    clk_time_t r;
    r = t;
    repeat (secs) r = next_second(r);
    return r;
  endfunction

  function automatic clk_time_t pick_alarm_target();
    clk_time_t t;
    if ($urandom_range(0, 4) != 0) begin
      t = later_by(clock_now, $urandom_range(0, 40));
    end else begin
      t.second  = $urandom_range(0, 63);
      t.minute  = $urandom_range(0, 63);
      t.hour    = $urandom_range(0, 31);
      t.weekday = $urandom_range(0, 7);
    end
    return t;
  endfunction

  task automatic run_alarm(inout logic armed, inout logic due, input clk_time_t at,
                           output alarm_stat_t stat);
    stat.fired = 1'b0;
    if (armed && due) begin
      due = 1'b0;
      if (clock_now == at) begin
        armed = 1'b0;
        stat.fired = 1'b1;
      end
    end
    stat.armed = armed;
  endtask

  task automatic step_clock(logic [1:0] op, logic [ELAPSED_W-1:0] counts);
    clock_report_t rep;
    logic [SUBSEC_W:0] sum;
    case (op)
      OP_TICK: begin
        sum = subsec_acc + counts;
        if (sum[SUBSEC_W]) sum = {1'b0, {SUBSEC_W{1'b1}}};
        if (sum >= COUNTS_PER_SECOND) begin
          sum = sum - COUNTS_PER_SECOND;
          clock_now = next_second(clock_now);
          sleep_due = 1'b1;
          wake_due = 1'b1;
        end
        subsec_acc = sum[SUBSEC_W-1:0];
      end
      OP_ARM_SLEEP: sleep_armed = 1'b1;
      OP_ARM_WAKE:  wake_armed = 1'b1;
      default: ;
    endcase
    run_alarm(sleep_armed, sleep_due, sleep_alarm_at, rep.sleep_stat);
    run_alarm(wake_armed, wake_due, wake_alarm_at, rep.wake_stat);
    rep.now = clock_now;
    pending_reports.push_back(rep);
  endtask

  task automatic send_item(logic [1:0] op, logic [ELAPSED_W-1:0] counts);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_elapsed_counts <= counts;
    do @(posedge clk); while (!in_ready);
    step_clock(op, counts);
  endtask

  task automatic wait_clock_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight alarm registers; call only while the clock is idle.
  task automatic program_alarms(clk_time_t sleep_t, clk_time_t wake_t);
    clk_time_t src;
    logic bank;
    field_t fld;
    logic [CFG_DATA_W-1:0] data;
    int idx;
    for (idx = 0; idx < 8; idx++) begin
      bank = (idx >= 4) ? CFG_BANK_WAKE : CFG_BANK_SLEEP;
      fld = field_t'(idx % 4);
      src = (bank == CFG_BANK_WAKE) ? wake_t : sleep_t;
      case (fld)
        FLD_SECOND: data = src.second;
        FLD_MINUTE: data = src.minute;
        FLD_HOUR:   data = CFG_DATA_W'(src.hour);
        default:    data = CFG_DATA_W'(src.weekday);
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= {bank, fld};
      cfg_data <= data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    sleep_alarm_at = sleep_t;
    wake_alarm_at = wake_t;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    clock_report_t want;
    if (out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transaction with no expected result", $time);
      end else begin
        want = pending_reports.pop_front();
        check_field("now_second", out_now_second, want.now.second);
        check_field("now_minute", out_now_minute, want.now.minute);
        check_field("now_hour", out_now_hour, want.now.hour);
        check_field("now_weekday", out_now_weekday, want.now.weekday);
        check_field("sleep_fired", out_sleep_fired, want.sleep_stat.fired);
        check_field("wake_fired", out_wake_fired, want.wake_stat.fired);
        check_field("sleep_is_armed", out_sleep_is_armed, want.sleep_stat.armed);
        check_field("wake_is_armed", out_wake_is_armed, want.wake_stat.armed);
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_and_large_ticks();
    wait_clock_idle();
    send_item(OP_ARM_SLEEP, ELAPSED_MAX);
    send_item(OP_TICK, '0);
    repeat (4) send_item(OP_TICK, ELAPSED_MAX);
    repeat (2) send_item(OP_TICK, '0);
    send_item(OP_UNUSED, ELAPSED_MAX);
    send_item(OP_ARM_WAKE, '0);
  endtask

  task automatic test_alarm_on_tick();
    wait_clock_idle();
    program_alarms(later_by(clock_now, 1), later_by(clock_now, 2));
    repeat (2) send_item(OP_TICK, COUNTS_PER_SECOND);
  endtask

  task automatic test_alarm_on_arm();
    wait_clock_idle();
    program_alarms(later_by(clock_now, 1), later_by(clock_now, 1));
    send_item(OP_TICK, COUNTS_PER_SECOND);
    send_item(OP_UNUSED, '0);
    send_item(OP_ARM_SLEEP, '0);
    send_item(OP_ARM_WAKE, '0);
    send_item(OP_ARM_SLEEP, '0);
    send_item(OP_TICK, '0);
  endtask

  task automatic test_unreachable_settings();
    clk_time_t sleep_t;
    clk_time_t wake_t;
    wait_clock_idle();
    sleep_t = later_by(clock_now, 1);
    sleep_t.hour = 5'd31;
    wake_t = later_by(clock_now, 1);
    wake_t.second = 6'd60;
    program_alarms(sleep_t, wake_t);
    send_item(OP_ARM_WAKE, ELAPSED_MAX);
    repeat (2) send_item(OP_TICK, COUNTS_PER_SECOND);
  endtask

  task automatic test_output_backpressure();
    wait_clock_idle();
    idling_on = 1'b0;
    hold_off_cycles = 150;
    repeat (40) send_item(OP_TICK, $urandom_range(0, ELAPSED_MAX));
    wait_clock_idle();
    idling_on = 1'b1;
  endtask

  task automatic test_random_alarm_rounds(int unsigned n_items);
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    logic [ELAPSED_W-1:0] counts;
    sent = 0;
    while (sent < n_items) begin
      wait_clock_idle();
      idling_on = ($urandom_range(0, 3) != 0);
      program_alarms(pick_alarm_target(), pick_alarm_target());
      n = $urandom_range(20, 60);
      repeat (n) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_item(OP_ARM_SLEEP, $urandom_range(0, ELAPSED_MAX));
        end else if (pick < 24) begin
          send_item(OP_ARM_WAKE, $urandom_range(0, ELAPSED_MAX));
        end else if (pick < 30) begin
          send_item(OP_UNUSED, $urandom_range(0, ELAPSED_MAX));
        end else begin
          case ($urandom_range(0, 4))
            0: counts = COUNTS_PER_SECOND;
            1: counts = $urandom_range(0, ELAPSED_MAX);
            2: counts = $urandom_range(0, 5000);
            3: counts = $urandom_range(15000, 25000);
            default: counts = $urandom_range(0, 1) ? ELAPSED_MAX : '0;
          endcase
          send_item(OP_TICK, counts);
        end
      end
      sent += n;
    end
    wait_clock_idle();
  endtask

  // Every tick here advances exactly one second.
  task automatic test_stall_free_ticks();
    wait_clock_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    program_alarms(later_by(clock_now, 20), later_by(clock_now, 45));
    send_item(OP_ARM_SLEEP, '0);
    send_item(OP_ARM_WAKE, '0);
    repeat (60) send_item(OP_TICK, $urandom_range(COUNTS_PER_SECOND, ELAPSED_MAX));
  endtask

  initial begin : test_sequence
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idling_on = 1'b1;
    test_reset_and_large_ticks();
    test_alarm_on_tick();
    test_alarm_on_arm();
    test_unreachable_settings();
    test_output_backpressure();
    test_random_alarm_rounds(1100);
    idling_on = 1'b0;
    test_stall_free_ticks();
    wait_clock_idle();
    if (mismatch_count == 0) begin
      $display("PASS weekday_clock_with_alarms_unit");
    end else begin
      $display("FAIL weekday_clock_with_alarms_unit");
    end
    $finish;
  end

  initial begin : run_limit
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL weekday_clock_with_alarms_unit");
    $finish;
  end

endmodule
